// ===== rtl/rmq_pkg.sv =====
package rmq_pkg;
  localparam int FRAC_BITS = 14;
  localparam int CFG_W = 14;
  localparam int ELEM_W = 16;
  localparam int QUAT_W = 16;

  typedef enum logic [1:0] {
    BR_TRACE = 2'd0,
    BR_M11   = 2'd1,
    BR_M22   = 2'd2,
    BR_M33   = 2'd3
  } branch_t;

  // values in the front to back queue
  typedef struct packed {
    logic [1:0]         branch;
    logic               fault;
    logic signed [19:0] rad;
    logic signed [17:0] n0;
    logic signed [17:0] n1;
    logic signed [17:0] n2;
  } job_t;
endpackage

// ===== rtl/rmq_front.sv =====
module rmq_front
  import rmq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     vld,
  input  logic [CFG_W-1:0]         thr,
  input  logic signed [ELEM_W-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33,
  output logic                     job_vld_r,
  output job_t                     job_r
);
  localparam logic signed [19:0] ONE = 20'sd1 <<< FRAC_BITS;

  logic signed [19:0] a11, a22, a33, t;
  job_t job_nxt;

  assign a11 = 20'(m11);
  assign a22 = 20'(m22);
  assign a33 = 20'(m33);
  assign t = a11 + a22 + a33 + ONE;

  // pick the branch and its radicand and numerators
  always_comb begin
    job_nxt = '0;
    if (t > $signed({6'd0, thr})) begin
      job_nxt.branch = BR_TRACE;
      job_nxt.rad = t;
      job_nxt.n0 = 18'(m32) - 18'(m23);
      job_nxt.n1 = 18'(m13) - 18'(m31);
      job_nxt.n2 = 18'(m21) - 18'(m12);
    end else if (a11 > a22 && a11 > a33) begin
      job_nxt.branch = BR_M11;
      job_nxt.rad = ONE + a11 - a22 - a33;
      job_nxt.n0 = 18'(m32) - 18'(m23);
      job_nxt.n1 = 18'(m12) + 18'(m21);
      job_nxt.n2 = 18'(m13) + 18'(m31);
    end else if (a22 > a33) begin
      job_nxt.branch = BR_M22;
      job_nxt.rad = ONE + a22 - a11 - a33;
      job_nxt.n0 = 18'(m13) - 18'(m31);
      job_nxt.n1 = 18'(m12) + 18'(m21);
      job_nxt.n2 = 18'(m23) + 18'(m32);
    end else begin
      job_nxt.branch = BR_M33;
      job_nxt.rad = ONE + a33 - a11 - a22;
      job_nxt.n0 = 18'(m21) - 18'(m12);
      job_nxt.n1 = 18'(m13) + 18'(m31);
      job_nxt.n2 = 18'(m23) + 18'(m32);
    end
    job_nxt.fault = (job_nxt.rad <= 20'sd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_vld_r <= 1'b0;
    end else begin
      job_vld_r <= vld;
    end
    job_r <= job_nxt;
  end
endmodule

// ===== rtl/rmq_queue.sv =====
module rmq_queue
  import rmq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_vld,
  input  job_t in_job,
  output logic out_vld_r,
  output job_t out_job_r
);
  // single-entry queue stage between front and back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= in_vld;
    end
    if (in_vld) begin
      out_job_r <= in_job;
    end
  end
endmodule

// ===== rtl/rmq_back.sv =====
module rmq_back
  import rmq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     job_vld,
  input  job_t                     job,
  output logic                     out_vld_r,
  output logic signed [QUAT_W-1:0] w_r, x_r, y_r, z_r,
  output logic [1:0]               br_r,
  output logic                     fault_r
);
  // radicand << FRAC_BITS, root bits, quotient bits
  localparam int RW = 20 + FRAC_BITS;
  localparam int SW = (RW + 1) / 2;
  localparam int NSQ = SW;
  localparam int NW = 17 + FRAC_BITS + 1;
  localparam int QB = 17;
  localparam int NDV = QB;
  localparam int DW = SW + 1;

  // square root pipeline: one result bit per stage
  logic [NSQ:0]                sv;
  logic [RW-1:0]               srem [NSQ+1];
  logic [SW-1:0]               sroot [NSQ+1];
  logic [1:0]                  sbr [NSQ+1];
  logic                        sflt [NSQ+1];
  logic signed [17:0]          sn [NSQ+1][3];

  assign sv[0] = job_vld;
  assign srem[0] = job.fault ? '0 : RW'(job.rad) << FRAC_BITS;
  assign sroot[0] = '0;
  assign sbr[0] = job.branch;
  assign sflt[0] = job.fault;
  assign sn[0][0] = job.n0;
  assign sn[0][1] = job.n1;
  assign sn[0][2] = job.n2;

  for (genvar i = 0; i < NSQ; i++) begin : g_sq
    localparam int SH = 2 * (NSQ - 1 - i);
    logic [RW+1:0] trial;
    logic [RW+1:0] acc;
    logic          take;
    assign trial = ({2'b0, RW'(sroot[i])} << (SH + 2)) | ((RW + 2)'(1) << SH);
    assign acc = {2'b0, srem[i]};
    assign take = acc >= trial;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        sv[i+1] <= 1'b0;
      end else begin
        sv[i+1] <= sv[i];
      end
      srem[i+1] <= take ? RW'(acc - trial) : srem[i];
      sroot[i+1] <= {sroot[i][SW-2:0], take};
      sbr[i+1] <= sbr[i];
      sflt[i+1] <= sflt[i];
      sn[i+1] <= sn[i];
    end
  end

  // restoring divide pipeline for three numerators, one quotient bit per stage
  logic [NDV:0]     dv;
  logic [DW-1:0]    dden [NDV+1];
  logic [SW-1:0]    dr [NDV+1];
  logic [1:0]       dbr [NDV+1];
  logic             dflt [NDV+1];
  logic             dneg [NDV+1][3];
  logic [QB-1:0]    dq [NDV+1][3];
  logic [NW-1:0]    dnum [NDV+1][3];

  assign dv[0] = sv[NSQ];
  assign dden[0] = {sroot[NSQ], 1'b0};
  assign dr[0] = sroot[NSQ];
  assign dbr[0] = sbr[NSQ];
  assign dflt[0] = sflt[NSQ];
  for (genvar k = 0; k < 3; k++) begin : g_di
    logic [17:0] mag;
    assign dneg[0][k] = sn[NSQ][k][17];
    assign mag = sn[NSQ][k][17] ? 18'(-sn[NSQ][k]) : 18'(sn[NSQ][k]);
    assign dnum[0][k] = (NW'(mag) << FRAC_BITS) + NW'(sroot[NSQ]);
    assign dq[0][k] = '0;
  end

  // long division: quotient bits from msb; a quotient at or past 2^QB
  // comes out all ones, which still saturates
  for (genvar i = 0; i < NDV; i++) begin : g_dv
    localparam int SH = QB - 1 - i;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv[i+1] <= 1'b0;
      end else begin
        dv[i+1] <= dv[i];
      end
      dden[i+1] <= dden[i];
      dr[i+1] <= dr[i];
      dbr[i+1] <= dbr[i];
      dflt[i+1] <= dflt[i];
      for (int k = 0; k < 3; k++) begin
        dneg[i+1][k] <= dneg[i][k];
        if ((dnum[i][k] >> SH) >= NW'(dden[i])) begin
          dnum[i+1][k] <= dnum[i][k] - (NW'(dden[i]) << SH);
          dq[i+1][k] <= dq[i][k] | (QB'(1) << SH);
        end else begin
          dnum[i+1][k] <= dnum[i][k];
          dq[i+1][k] <= dq[i][k];
        end
      end
    end
  end

  // sign, saturate, place into components
  function automatic logic signed [QUAT_W-1:0] sat_q(input logic neg, input logic [QB-1:0] q);
    logic signed [QB:0] v;
    v = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[QUAT_W-1:0];
  endfunction

  logic signed [QUAT_W-1:0] c0, c1, c2, hf;
  logic [SW:0] half_w;
  assign c0 = sat_q(dneg[NDV][0], dq[NDV][0]);
  assign c1 = sat_q(dneg[NDV][1], dq[NDV][1]);
  assign c2 = sat_q(dneg[NDV][2], dq[NDV][2]);
  assign half_w = ({1'b0, dr[NDV]} + 1'b1) >> 1;
  assign hf = (half_w > 32767) ? 16'sh7fff : $signed(half_w[QUAT_W-1:0]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= dv[NDV];
    end
    br_r <= dbr[NDV];
    fault_r <= dflt[NDV];
    if (dflt[NDV]) begin
      {w_r, x_r, y_r, z_r} <= '0;
    end else begin
      unique case (dbr[NDV])
        BR_TRACE: {w_r, x_r, y_r, z_r} <= {hf, c0, c1, c2};
        BR_M11:   {w_r, x_r, y_r, z_r} <= {c0, hf, c1, c2};
        BR_M22:   {w_r, x_r, y_r, z_r} <= {c0, c1, hf, c2};
        default:  {w_r, x_r, y_r, z_r} <= {c0, c1, c2, hf};
      endcase
    end
  end
endmodule

// ===== rtl/rotation_matrix_to_quaternion_top.sv =====
// channel  | ports                       | handshake
// request  | in_m11..in_m33              | start, accepted when busy low
// result   | out_quat_*, out_branch_taken, out_root_fault | out_valid, one cycle
// config   | cfg_trace_threshold         | cfg_we
// one request per cycle; a request passes the front register, the queue register,
// 17 root stages, 17 divide stages and 1 output register.
// the pipelined square root (one bit per stage) and divider set the latency.
// busy is always low; reset is synchronous and clears all valid flags.
// the receiver cannot stall; results leave in request order.
module rotation_matrix_to_quaternion_top
  import rmq_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [ELEM_W-1:0] in_m11, in_m12, in_m13,
  input  logic signed [ELEM_W-1:0] in_m21, in_m22, in_m23,
  input  logic signed [ELEM_W-1:0] in_m31, in_m32, in_m33,
  input  logic                     cfg_we,
  input  logic [CFG_W-1:0]         cfg_trace_threshold,
  output logic                     out_valid,
  output logic signed [QUAT_W-1:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z,
  output logic [1:0]               out_branch_taken,
  output logic                     out_root_fault
);
  logic [CFG_W-1:0] thr_r;
  logic fv, qv;
  job_t fj, qj;

  assign busy = 1'b0;

  // threshold register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= CFG_W'(1);
    end else if (cfg_we) begin
      thr_r <= cfg_trace_threshold;
    end
  end

  rmq_front u_front (
    .clk(clk), .rst_n(rst_n), .vld(start && !busy), .thr(thr_r),
    .m11(in_m11), .m12(in_m12), .m13(in_m13), .m21(in_m21), .m22(in_m22),
    .m23(in_m23), .m31(in_m31), .m32(in_m32), .m33(in_m33),
    .job_vld_r(fv), .job_r(fj)
  );

  rmq_queue u_queue (
    .clk(clk), .rst_n(rst_n), .in_vld(fv), .in_job(fj),
    .out_vld_r(qv), .out_job_r(qj)
  );

  rmq_back u_back (
    .clk(clk), .rst_n(rst_n), .job_vld(qv), .job(qj),
    .out_vld_r(out_valid), .w_r(out_quat_w), .x_r(out_quat_x), .y_r(out_quat_y),
    .z_r(out_quat_z), .br_r(out_branch_taken), .fault_r(out_root_fault)
  );
endmodule

// ===== rtl/rmq_checker.sv =====
module rmq_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_root_fault,
  input logic signed [15:0] out_quat_w, out_quat_x, out_quat_y, out_quat_z,
  input logic [1:0] out_branch_taken
);
  // faulted result carries zero quaternion
  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_root_fault |-> out_quat_w == 0 && out_quat_x == 0 &&
    out_quat_y == 0 && out_quat_z == 0) else $error("fault with nonzero quat");
  // trace branch never faults
  a_trace_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_branch_taken == 2'd0 |-> !out_root_fault)
    else $error("trace branch fault");
  // no result right after reset
  a_rst: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result after reset");
  // never busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");
endmodule

bind rotation_matrix_to_quaternion_top rmq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_root_fault(out_root_fault), .out_quat_w(out_quat_w), .out_quat_x(out_quat_x),
  .out_quat_y(out_quat_y), .out_quat_z(out_quat_z), .out_branch_taken(out_branch_taken)
);

// ===== tb/tb_rotation_matrix_to_quaternion_top.sv =====
module tb_rotation_matrix_to_quaternion_top;
  import rmq_pkg::*;

  localparam int FB = FRAC_BITS;
  localparam int DRAIN_CYCLES = 120;

  typedef struct {
    logic signed [ELEM_W-1:0] e[9];
  } matrix_t;

  typedef struct {
    logic signed [QUAT_W-1:0] w, x, y, z;
    branch_t                  branch;
    logic                     fault;
  } quat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [ELEM_W-1:0] m11 = '0, m12 = '0, m13 = '0;
  logic signed [ELEM_W-1:0] m21 = '0, m22 = '0, m23 = '0;
  logic signed [ELEM_W-1:0] m31 = '0, m32 = '0, m33 = '0;
  logic cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_thr = '0;
  logic out_valid;
  logic signed [QUAT_W-1:0] q_w, q_x, q_y, q_z;
  logic [1:0] q_branch;
  logic q_fault;

  quat_t pending_quats[$];
  logic [CFG_W-1:0] thr_model = 1;
  int sender_idle_pct = 0;
  int error_count = 0;

  always #4 clk = ~clk;

  rotation_matrix_to_quaternion_top dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_m11(m11), .in_m12(m12), .in_m13(m13),
    .in_m21(m21), .in_m22(m22), .in_m23(m23),
    .in_m31(m31), .in_m32(m32), .in_m33(m33),
    .cfg_we(cfg_we), .cfg_trace_threshold(cfg_thr),
    .out_valid(out_valid), .out_quat_w(q_w), .out_quat_x(q_x),
    .out_quat_y(q_y), .out_quat_z(q_z),
    .out_branch_taken(q_branch), .out_root_fault(q_fault)
  );

  // bitwise integer square root
  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // n / (2r), rounded half away from zero
  function automatic longint div_by_2r(longint n, longint unsigned r);
    longint unsigned mag;
    longint unsigned q;
    mag = (n < 0) ? longint'(-n) : longint'(n);
    q = ((mag << FB) + r) / (r << 1);
    return (n < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic logic signed [QUAT_W-1:0] clamp16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  // expected quaternion for one matrix under the current threshold
  function automatic quat_t matrix_to_quat(matrix_t m, logic [CFG_W-1:0] thr);
    longint a[9];
    longint one;
    longint t;
    longint rad;
    longint q[4];
    longint unsigned r;
    longint half;
    quat_t res;
    for (int i = 0; i < 9; i++) a[i] = m.e[i];
    one = longint'(1) << FB;
    t = a[0] + a[4] + a[8] + one;
    q = '{0, 0, 0, 0};
    if (t > longint'(thr)) begin
      res.branch = BR_TRACE;
      rad = t;
    end else if (a[0] > a[4] && a[0] > a[8]) begin
      res.branch = BR_M11;
      rad = one + a[0] - a[4] - a[8];
    end else if (a[4] > a[8]) begin
      res.branch = BR_M22;
      rad = one + a[4] - a[0] - a[8];
    end else begin
      res.branch = BR_M33;
      rad = one + a[8] - a[0] - a[4];
    end
    res.fault = (rad <= 0);
    if (!res.fault) begin
      r = int_sqrt(longint'(rad) << FB);
      half = longint'((r + 1) >> 1);
      case (res.branch)
        BR_TRACE: begin
          q[0] = half;
          q[1] = div_by_2r(a[7] - a[5], r);
          q[2] = div_by_2r(a[2] - a[6], r);
          q[3] = div_by_2r(a[3] - a[1], r);
        end
        BR_M11: begin
          q[0] = div_by_2r(a[7] - a[5], r);
          q[1] = half;
          q[2] = div_by_2r(a[1] + a[3], r);
          q[3] = div_by_2r(a[2] + a[6], r);
        end
        BR_M22: begin
          q[0] = div_by_2r(a[2] - a[6], r);
          q[1] = div_by_2r(a[1] + a[3], r);
          q[2] = half;
          q[3] = div_by_2r(a[5] + a[7], r);
        end
        default: begin
          q[0] = div_by_2r(a[3] - a[1], r);
          q[1] = div_by_2r(a[2] + a[6], r);
          q[2] = div_by_2r(a[5] + a[7], r);
          q[3] = half;
        end
      endcase
    end
    res.w = clamp16(q[0]);
    res.x = clamp16(q[1]);
    res.y = clamp16(q[2]);
    res.z = clamp16(q[3]);
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // result checker
  always @(posedge clk) begin
    quat_t e;
    if (rst_n && out_valid) begin
      if (pending_quats.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        e = pending_quats.pop_front();
        if (q_w !== e.w) report_mismatch("quat_w", q_w, e.w);
        if (q_x !== e.x) report_mismatch("quat_x", q_x, e.x);
        if (q_y !== e.y) report_mismatch("quat_y", q_y, e.y);
        if (q_z !== e.z) report_mismatch("quat_z", q_z, e.z);
        if (q_branch !== e.branch) report_mismatch("branch_taken", q_branch, e.branch);
        if (q_fault !== e.fault) report_mismatch("root_fault", q_fault, e.fault);
      end
    end
  end

  // send one request; called just after a rising edge
  task automatic send_matrix(matrix_t m);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    m11 <= m.e[0]; m12 <= m.e[1]; m13 <= m.e[2];
    m21 <= m.e[3]; m22 <= m.e[4]; m23 <= m.e[5];
    m31 <= m.e[6]; m32 <= m.e[7]; m33 <= m.e[8];
    do @(posedge clk); while (busy);
    pending_quats.push_back(matrix_to_quat(m, thr_model));
  endtask

  // stop sending and wait for every outstanding result
  task automatic drain;
    int guard;
    start <= 1'b0;
    guard = 0;
    @(posedge clk);
    while (pending_quats.size() > 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic write_threshold(logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_thr <= v;
    @(posedge clk);
    thr_model = v;
    cfg_we <= 1'b0;
  endtask

  function automatic matrix_t diag_matrix(int d1, int d2, int d3, int off);
    matrix_t m;
    for (int i = 0; i < 9; i++) m.e[i] = ELEM_W'(off);
    m.e[0] = ELEM_W'(d1);
    m.e[4] = ELEM_W'(d2);
    m.e[8] = ELEM_W'(d3);
    return m;
  endfunction

  function automatic matrix_t random_matrix();
    matrix_t m;
    int kind;
    int shared;
    kind = $urandom_range(3);
    for (int i = 0; i < 9; i++) m.e[i] = ELEM_W'($urandom);
    if (kind == 1) begin
      // small magnitudes, rotation-like range
      for (int i = 0; i < 9; i++) m.e[i] = ELEM_W'(int'($urandom_range(32768)) - 16384);
    end else if (kind == 2) begin
      // diagonal ties
      shared = int'($urandom);
      m.e[0] = ELEM_W'(shared);
      m.e[4] = ELEM_W'(shared);
      if ($urandom_range(1)) m.e[8] = ELEM_W'(shared);
    end
    return m;
  endfunction

  task automatic test_directed;
    matrix_t m;
    send_matrix(diag_matrix(16384, 16384, 16384, 0));
    send_matrix(diag_matrix(-16384, -16384, -16384, 0));
    send_matrix(diag_matrix(16384, -16384, -16384, 0));
    send_matrix(diag_matrix(-16384, 16384, -16384, 0));
    send_matrix(diag_matrix(-16384, -16384, 16384, 0));
    send_matrix(diag_matrix(32767, 32767, 32767, 32767));
    send_matrix(diag_matrix(-32768, -32768, -32768, -32768));
    send_matrix(diag_matrix(-32768, -32768, -32768, 32767));
    send_matrix(diag_matrix(32767, 32767, 32767, -32768));
    send_matrix(diag_matrix(-8192, -8192, -8192, 0));
    send_matrix(diag_matrix(-16384, -16384, 0, 0));
    send_matrix(diag_matrix(0, 0, -32768, 0));
    // asymmetric extremes on the off-diagonals
    m = diag_matrix(-32768, -32768, -32768, 0);
    m.e[1] = -32768; m.e[3] = 32767; m.e[2] = 32767;
    m.e[6] = -32768; m.e[5] = -32768; m.e[7] = 32767;
    send_matrix(m);
    m.e[0] = 32767; m.e[4] = 32767; m.e[8] = 32767;
    send_matrix(m);
    write_threshold(16383);
    send_matrix(diag_matrix(0, 0, 0, 0));
    send_matrix(diag_matrix(-1, -1, -1, 5));
    send_matrix(diag_matrix(-16384, -16384, -16384, 16384));
    send_matrix(diag_matrix(100, 100, -20000, -7));
    send_matrix(diag_matrix(-32768, -32768, -32768, 32767));
    write_threshold(0);
    send_matrix(diag_matrix(0, -16384, 0, 0));
    send_matrix(diag_matrix(-16385, 0, 0, 3));
    send_matrix(diag_matrix(-16384, 0, 0, -3));
  endtask

  task automatic test_random(int count, int idle_pct);
    sender_idle_pct = idle_pct;
    for (int i = 0; i < count; i++) begin
      if (i % 150 == 149) begin
        case ($urandom_range(2))
          0: write_threshold(0);
          1: write_threshold(16383);
          default: write_threshold(CFG_W'($urandom_range(16383)));
        endcase
      end
      send_matrix(random_matrix());
    end
    drain();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(560, 37);
    write_threshold(16383);
    test_random(560, 49);
    write_threshold(1);
    test_random(560, 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && pending_quats.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule

// ===== files.f =====
rtl/rmq_pkg.sv
rtl/rmq_front.sv
rtl/rmq_queue.sv
rtl/rmq_back.sv
rtl/rotation_matrix_to_quaternion_top.sv
rtl/rmq_checker.sv
tb/tb_rotation_matrix_to_quaternion_top.sv
